// File: hw/rtl/assert_macros.svh
// assertion helpers shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/rycc_pkg.sv
package rycc_pkg;

  // field widths
  localparam int COMP_W  = 8;
  localparam int CNT_W   = 12;
  localparam int SIZE_W  = 13;
  localparam int INDEX_W = 8;

  // frame size limits
  localparam logic [SIZE_W-1:0] SIZE_MIN = 13'd2;
  localparam logic [SIZE_W-1:0] SIZE_MAX = 13'd4096;
  localparam logic [CNT_W-1:0]  LAST_COL_RESET = 12'd639;
  localparam logic [CNT_W-1:0]  LAST_ROW_RESET = 12'd479;

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // q8 arithmetic
  localparam int SUM_W = 18;
  localparam int SHR_W = SUM_W - 8;
  localparam int OFF_W = 10;
  localparam int VAL_W = SHR_W + 1;

  localparam logic signed [8:0] C_YR  = 9'sd66;
  localparam logic signed [8:0] C_YG  = 9'sd129;
  localparam logic signed [8:0] C_YB  = 9'sd25;
  localparam logic signed [8:0] C_BR  = -9'sd38;
  localparam logic signed [8:0] C_BG  = -9'sd74;
  localparam logic signed [8:0] C_BB  = 9'sd112;
  localparam logic signed [8:0] C_RR  = 9'sd112;
  localparam logic signed [8:0] C_RG  = -9'sd94;
  localparam logic signed [8:0] C_RB  = -9'sd18;
  localparam logic signed [OFF_W-1:0] OFF_Y = 10'sd16;
  localparam logic signed [OFF_W-1:0] OFF_C = 10'sd128;
  localparam logic signed [SUM_W-1:0] Q8_ROUND = 18'sd128;

  // configuration register indexes
  typedef enum logic [INDEX_W-1:0] {
    REG_FRAME_WIDTH  = 8'd0,
    REG_FRAME_HEIGHT = 8'd1
  } cfg_reg_t;

  // last column and row positions, already clamped
  typedef struct packed {
    logic [CNT_W-1:0] last_col;
    logic [CNT_W-1:0] last_row;
  } frame_lim_t;

  // classified pixel in the queue
  typedef struct packed {
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;
    logic              chroma;
    logic              eol;
    logic              eof;
  } q_entry_t;

  // queue status toward front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // clamp a size register and return its last position
  function automatic logic [CNT_W-1:0] last_pos(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] c;
    logic [SIZE_W-1:0] m;
    c = v;
    if (v < SIZE_MIN) begin
      c = SIZE_MIN;
    end else if (v > SIZE_MAX) begin
      c = SIZE_MAX;
    end
    m = c - 13'd1;
    return m[CNT_W-1:0];
  endfunction

  // weighted q8 sum with rounding, offset and saturation
  function automatic logic [COMP_W-1:0] weigh(
    input logic signed [8:0]        cr,
    input logic signed [8:0]        cg,
    input logic signed [8:0]        cb,
    input logic [COMP_W-1:0]        r,
    input logic [COMP_W-1:0]        g,
    input logic [COMP_W-1:0]        b,
    input logic signed [OFF_W-1:0]  off
  );
    logic signed [SUM_W-1:0] pr;
    logic signed [SUM_W-1:0] pg;
    logic signed [SUM_W-1:0] pb;
    logic signed [SUM_W-1:0] sum;
    logic signed [SHR_W-1:0] shr;
    logic signed [VAL_W-1:0] v;
    logic [COMP_W-1:0]       res;
    pr  = SUM_W'(cr) * SUM_W'($signed({1'b0, r}));
    pg  = SUM_W'(cg) * SUM_W'($signed({1'b0, g}));
    pb  = SUM_W'(cb) * SUM_W'($signed({1'b0, b}));
    sum = pr + pg + pb + Q8_ROUND;
    shr = sum[SUM_W-1:8];
    v   = VAL_W'(shr) + VAL_W'(off);
    if (v < 0) begin
      res = '0;
    end else if (v > 11'sd255) begin
      res = '1;
    end else begin
      res = v[COMP_W-1:0];
    end
    return res;
  endfunction

endpackage

// File: hw/rtl/rycc_ifs.sv
// pixel input channel
interface rycc_pix_if import rycc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [COMP_W-1:0] red;
  logic [COMP_W-1:0] green;
  logic [COMP_W-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink (input valid, red, green, blue, output ready);
endinterface

// ycbcr result channel
interface rycc_ycc_if import rycc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [COMP_W-1:0] luma;
  logic [COMP_W-1:0] chroma_blue;
  logic [COMP_W-1:0] chroma_red;
  logic              chroma_valid;
  logic              end_of_line;
  logic              end_of_frame;

  modport source (output valid, luma, chroma_blue, chroma_red, chroma_valid,
                  end_of_line, end_of_frame, input ready);
  modport sink (input valid, luma, chroma_blue, chroma_red, chroma_valid,
                end_of_line, end_of_frame, output ready);
endinterface

// configuration write channel
interface rycc_cfg_if import rycc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] index;
  logic [SIZE_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/rgb_to_ycbcr420_converter.sv
// RGB888 to BT.601 studio-range YCbCr 4:2:0 converter.
// pixel_in carries one RGB pixel per transaction in raster order; pixel_out
// gives one transaction per pixel with its luma, and on the top-left pixel of
// every 2x2 block also Cb/Cr (chroma_valid high, chroma zero otherwise), plus
// end_of_line and end_of_frame flags from the internal column/row counters.
// cfg writes frame_width (index 0) and frame_height (index 1); values below 2
// act as 2, above 4096 as 4096. Write only while no pixel is in flight.
// Throughput: one pixel per clock while pixel_out is ready. An accepted input
// passes through the four-entry queue and then the conversion stage, whose
// constant multiplies feed the output register. When pixel_out stalls, the
// output register holds its result and the queue keeps taking pixels until
// its four entries are full, then pixel_in.ready drops. Reset clears the
// counters to the first pixel of a frame, empties the queue and output, and
// sets the frame size to 640x480.
module rgb_to_ycbcr420_converter import rycc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  rycc_pix_if.sink    pixel_in,
  rycc_ycc_if.source  pixel_out,
  rycc_cfg_if.sink    cfg
);

  frame_lim_t lim;
  q_stat_t    qstat;
  q_entry_t   wr_entry;
  q_entry_t   head;
  logic       push;
  logic       pop;

  // configuration registers, stored as clamped last positions
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lim.last_col <= LAST_COL_RESET;
      lim.last_row <= LAST_ROW_RESET;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_FRAME_WIDTH:  lim.last_col <= last_pos(cfg.data);
        REG_FRAME_HEIGHT: lim.last_row <= last_pos(cfg.data);
        default:          lim <= lim;
      endcase
    end
  end

  rycc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .pixel_in (pixel_in),
    .lim      (lim),
    .qstat    (qstat),
    .push     (push),
    .entry    (wr_entry)
  );

  rycc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .pop      (pop),
    .head     (head),
    .qstat    (qstat)
  );

  rycc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .qstat     (qstat),
    .pop       (pop),
    .pixel_out (pixel_out)
  );

endmodule

// File: hw/rtl/rycc_front.sv
`include "assert_macros.svh"

module rycc_front import rycc_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  rycc_pix_if.sink      pixel_in,
  input  frame_lim_t    lim,
  input  q_stat_t       qstat,
  output logic          push,
  output q_entry_t      entry
);

  logic [CNT_W-1:0] column_count;
  logic [CNT_W-1:0] row_count;
  logic [CNT_W-1:0] column_count_next;
  logic [CNT_W-1:0] row_count_next;
  logic             eol;
  logic             eof;

  // accept whenever the queue has room
  assign pixel_in.ready = !qstat.full;
  assign push           = pixel_in.valid && !qstat.full;

  // classify the pixel by its frame position
  assign eol = column_count >= lim.last_col;
  assign eof = eol && (row_count >= lim.last_row);

  always_comb begin
    entry.red    = pixel_in.red;
    entry.green  = pixel_in.green;
    entry.blue   = pixel_in.blue;
    entry.chroma = !column_count[0] && !row_count[0];
    entry.eol    = eol;
    entry.eof    = eof;
  end

  // position counters
  always_comb begin
    column_count_next = column_count;
    row_count_next    = row_count;
    if (push) begin
      if (eol) begin
        column_count_next = '0;
        row_count_next    = eof ? '0 : row_count + 12'd1;
      end else begin
        column_count_next = column_count + 12'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  `ASSERT_NEXT(a_eol_wraps, clk, rst, push && eol, column_count == '0,
               "column counter did not wrap after end of line")

endmodule

// File: hw/rtl/rycc_queue.sv
`include "assert_macros.svh"

module rycc_queue import rycc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  q_entry_t wr_entry,
  input  logic     pop,
  output q_entry_t head,
  output q_stat_t  qstat
);

  q_entry_t         slots [QDEPTH];
  logic [QAW-1:0]   wr_ptr;
  logic [QAW-1:0]   rd_ptr;
  logic [QCW-1:0]   count;

  assign qstat.full  = count == QCW'(QDEPTH);
  assign qstat.empty = count == '0;
  assign head        = slots[rd_ptr];

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QAW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QAW'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + QCW'(1);
        2'b01:   count <= count - QCW'(1);
        default: count <= count;
      endcase
    end
  end

  `ASSERT_SAME(a_no_overflow, clk, rst, qstat.full, !push,
               "push into a full queue")
  `ASSERT_SAME(a_no_underflow, clk, rst, qstat.empty, !pop,
               "pop from an empty queue")

endmodule

// File: hw/rtl/rycc_back.sv
`include "assert_macros.svh"

module rycc_back import rycc_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  q_entry_t      head,
  input  q_stat_t       qstat,
  output logic          pop,
  rycc_ycc_if.source    pixel_out
);

  logic out_valid;

  // take the next entry when the output register is free or draining
  assign pop             = !qstat.empty && (!out_valid || pixel_out.ready);
  assign pixel_out.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (pixel_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  // color conversion into the output register
  always_ff @(posedge clk) begin
    if (pop) begin
      pixel_out.luma <= weigh(C_YR, C_YG, C_YB, head.red, head.green, head.blue, OFF_Y);
      pixel_out.chroma_blue <= head.chroma
        ? weigh(C_BR, C_BG, C_BB, head.red, head.green, head.blue, OFF_C) : '0;
      pixel_out.chroma_red <= head.chroma
        ? weigh(C_RR, C_RG, C_RB, head.red, head.green, head.blue, OFF_C) : '0;
      pixel_out.chroma_valid <= head.chroma;
      pixel_out.end_of_line  <= head.eol;
      pixel_out.end_of_frame <= head.eof;
    end
  end

  `ASSERT_NEXT(a_pop_shows, clk, rst, pop, out_valid,
               "popped entry did not reach the output register")

endmodule
